[rtl/core/aat_pkg.sv]
// ----------------------------------------------------------------------------
// Active alarm table: shared package
// Payload types, request codes, datapath commands, controller states.
// ----------------------------------------------------------------------------
package aat_pkg;

    // request codes carried in req_type
    localparam logic [1:0] REQ_APPEND = 2'd0;
    localparam logic [1:0] REQ_DELETE = 2'd1;
    localparam logic [1:0] REQ_READ   = 2'd2;

    // configuration register indexes
    localparam logic CFG_CRITICAL = 1'b0;
    localparam logic CFG_MAJOR    = 1'b1;

    localparam logic [1:0] CRITICAL_RESET = 2'd3;
    localparam logic [1:0] MAJOR_RESET    = 2'd2;

    // severity code sits in id bits 9:8
    localparam int unsigned SEV_LSB = 8;
    localparam int unsigned SEV_W   = 2;

    localparam int unsigned RESULT_LIMIT = 32;
    localparam int unsigned CNT_OUT_W    = 6;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [15:0] alm_id;
        logic [15:0] alm_value;
        logic [4:0]  read_index;
        logic [5:0]  read_count;
    } t_req;

    typedef struct packed {
        logic        ok;
        logic [15:0] entry_id;
        logic [15:0] entry_value;
        logic [5:0]  total_count;
        logic [5:0]  critical_count;
        logic [5:0]  major_count;
        logic [5:0]  minor_count;
        logic        alarm_active;
        logic        beep;
        logic        last;
    } t_rsp;

    typedef struct packed {
        logic [15:0] id;
        logic [15:0] value;
    } t_entry;

    typedef enum logic [3:0] {
        DP_IDLE,
        DP_CAPTURE,
        DP_APPEND,
        DP_REC_INIT,
        DP_REC_STEP,
        DP_DEL_SEARCH,
        DP_DEL_SHIFT,
        DP_RD_INIT,
        DP_RD_FETCH,
        DP_RD_EMIT,
        DP_ACK,
        DP_NAK
    } t_dp_op;

    typedef struct packed {
        logic full;
        logic rec_done;
        logic hit;
        logic miss;
        logic shift_done;
        logic rd_bad;
        logic rd_none;
        logic rd_last;
        logic slot_free;
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_APPEND,
        S_REC_INIT,
        S_REC_RUN,
        S_DEL_SEARCH,
        S_DEL_SHIFT,
        S_RD_INIT,
        S_RD_FETCH,
        S_RD_EMIT,
        S_ACK,
        S_NAK
    } t_state;

endpackage

[rtl/core/aat_chan_if.sv]
// ----------------------------------------------------------------------------
// Active alarm table: valid/ready channel
// Carries one payload word per handshake.
// ----------------------------------------------------------------------------
interface aat_chan_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

[rtl/core/aat_ctrl.sv]
// ----------------------------------------------------------------------------
// Active alarm table: controller
// Sequences append, delete, recount and read over the datapath.
// ----------------------------------------------------------------------------
module aat_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic [1:0]         i_req_type,
    output logic               o_ready,
    output aat_pkg::t_dp_op    o_op,
    input  aat_pkg::t_status   i_status
);

    aat_pkg::t_state r_state;
    aat_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= aat_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_op    = aat_pkg::DP_IDLE;
        o_ready = 1'b0;
        unique case (r_state)
            aat_pkg::S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_op = aat_pkg::DP_CAPTURE;
                    case (i_req_type)
                        aat_pkg::REQ_APPEND: begin
                            n_state = i_status.full ? aat_pkg::S_NAK : aat_pkg::S_APPEND;
                        end
                        aat_pkg::REQ_DELETE: n_state = aat_pkg::S_DEL_SEARCH;
                        aat_pkg::REQ_READ:   n_state = aat_pkg::S_RD_INIT;
                        default:             n_state = aat_pkg::S_NAK;
                    endcase
                end
            end
            aat_pkg::S_APPEND: begin
                o_op    = aat_pkg::DP_APPEND;
                n_state = aat_pkg::S_REC_INIT;
            end
            aat_pkg::S_REC_INIT: begin
                o_op    = aat_pkg::DP_REC_INIT;
                n_state = aat_pkg::S_REC_RUN;
            end
            aat_pkg::S_REC_RUN: begin
                o_op = aat_pkg::DP_REC_STEP;
                if (i_status.rec_done) begin
                    n_state = aat_pkg::S_ACK;
                end
            end
            aat_pkg::S_DEL_SEARCH: begin
                o_op = aat_pkg::DP_DEL_SEARCH;
                if (i_status.hit) begin
                    n_state = aat_pkg::S_DEL_SHIFT;
                end else if (i_status.miss) begin
                    n_state = aat_pkg::S_NAK;
                end
            end
            aat_pkg::S_DEL_SHIFT: begin
                o_op = aat_pkg::DP_DEL_SHIFT;
                if (i_status.shift_done) begin
                    n_state = aat_pkg::S_REC_INIT;
                end
            end
            aat_pkg::S_RD_INIT: begin
                o_op = aat_pkg::DP_RD_INIT;
                if (i_status.rd_bad) begin
                    n_state = aat_pkg::S_NAK;
                end else if (i_status.rd_none) begin
                    n_state = aat_pkg::S_IDLE;
                end else begin
                    n_state = aat_pkg::S_RD_FETCH;
                end
            end
            aat_pkg::S_RD_FETCH: begin
                o_op    = aat_pkg::DP_RD_FETCH;
                n_state = aat_pkg::S_RD_EMIT;
            end
            aat_pkg::S_RD_EMIT: begin
                // hold the fetched entry until the output slot opens
                if (i_status.slot_free) begin
                    o_op    = aat_pkg::DP_RD_EMIT;
                    n_state = i_status.rd_last ? aat_pkg::S_IDLE : aat_pkg::S_RD_FETCH;
                end
            end
            aat_pkg::S_ACK: begin
                if (i_status.slot_free) begin
                    o_op    = aat_pkg::DP_ACK;
                    n_state = aat_pkg::S_IDLE;
                end
            end
            aat_pkg::S_NAK: begin
                if (i_status.slot_free) begin
                    o_op    = aat_pkg::DP_NAK;
                    n_state = aat_pkg::S_IDLE;
                end
            end
            default: n_state = aat_pkg::S_IDLE;
        endcase
    end

endmodule

[rtl/core/aat_dp.sv]
// ----------------------------------------------------------------------------
// Active alarm table: datapath
// Entry memory (oldest at slot 0), pointers, severity counters, output word.
// ----------------------------------------------------------------------------
module aat_dp #(
    parameter int unsigned MAX_ALARMS = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic             i_cfg_idx,
    input  logic [1:0]       i_cfg_data,
    input  aat_pkg::t_req    i_req,
    input  aat_pkg::t_dp_op  i_op,
    output aat_pkg::t_status o_status,
    output logic             o_rsp_valid,
    input  logic             i_rsp_ready,
    output aat_pkg::t_rsp    o_rsp
);

    localparam int unsigned AW = (MAX_ALARMS > 1) ? $clog2(MAX_ALARMS) : 1;
    localparam int unsigned CW = $clog2(MAX_ALARMS + 1);
    localparam int unsigned NW = (CW > 6) ? CW : 6;

    aat_pkg::t_entry r_mem [MAX_ALARMS];
    aat_pkg::t_entry r_rd_data;
    aat_pkg::t_req   r_req;
    aat_pkg::t_rsp   r_out;
    logic            r_out_valid;

    logic [1:0]      r_crit_lvl;
    logic [1:0]      r_maj_lvl;
    logic [CW-1:0]   r_count;
    logic [CW-1:0]   r_crit;
    logic [CW-1:0]   r_maj;
    logic [CW-1:0]   r_min;
    logic            r_beep;
    logic [CW-1:0]   r_acc_crit;
    logic [CW-1:0]   r_acc_maj;
    logic [CW-1:0]   r_acc_min;
    logic [CW-1:0]   r_ptr;
    logic            r_pend;
    logic [CW-1:0]   r_pend_addr;
    logic [5:0]      r_rem;

    logic [AW-1:0]   w_rd_addr;
    logic            w_rd_en;
    logic [AW-1:0]   w_wr_addr;
    aat_pkg::t_entry w_wr_data;
    logic            w_we;
    logic            w_hit;
    logic            w_rec_done;
    logic            w_shift_done;
    logic [NW-1:0]   w_avail;
    logic [NW-1:0]   w_n;
    logic [1:0]      w_sev;
    logic            w_load;
    logic            w_slot_free;

    assign w_slot_free  = !r_out_valid || i_rsp_ready;
    assign w_hit        = r_pend && (r_rd_data.id == r_req.alm_id);
    assign w_rec_done   = (r_ptr == r_count) && !r_pend;
    assign w_shift_done = (r_ptr >= r_count) && !r_pend;
    assign w_sev        = r_rd_data.id[aat_pkg::SEV_LSB +: aat_pkg::SEV_W];

    always_comb begin
        w_avail = NW'(r_count) - NW'(r_req.read_index);
        w_n     = (NW'(r_req.read_count) < w_avail) ? NW'(r_req.read_count) : w_avail;
        if (w_n > NW'(aat_pkg::RESULT_LIMIT)) begin
            w_n = NW'(aat_pkg::RESULT_LIMIT);
        end
    end

    always_comb begin
        o_status            = '0;
        o_status.full       = (r_count >= CW'(MAX_ALARMS));
        o_status.rec_done   = w_rec_done;
        o_status.hit        = w_hit;
        o_status.miss       = !w_hit && (r_ptr == '0);
        o_status.shift_done = w_shift_done;
        o_status.rd_bad     = NW'(r_req.read_index) >= NW'(r_count);
        o_status.rd_none    = (r_req.read_count == '0);
        o_status.rd_last    = (r_rem == 6'd1);
        o_status.slot_free  = w_slot_free;
    end

    // memory read port: one address per cycle, picked by the current command
    always_comb begin
        w_rd_en   = 1'b0;
        w_rd_addr = AW'(r_ptr);
        case (i_op)
            aat_pkg::DP_REC_STEP: begin
                w_rd_en = (r_ptr != r_count);
            end
            aat_pkg::DP_DEL_SEARCH: begin
                w_rd_en   = (r_ptr != '0) && !w_hit;
                w_rd_addr = AW'(r_ptr - CW'(1));
            end
            aat_pkg::DP_DEL_SHIFT: begin
                w_rd_en = (r_ptr < r_count);
            end
            aat_pkg::DP_RD_FETCH: begin
                // logical position 0 is the newest, stored at the top slot
                w_rd_en   = 1'b1;
                w_rd_addr = AW'(r_count - CW'(1) - r_ptr);
            end
            default: w_rd_en = 1'b0;
        endcase
    end

    always_comb begin
        w_we      = 1'b0;
        w_wr_addr = AW'(r_count);
        w_wr_data = '{id: r_req.alm_id, value: r_req.alm_value};
        if (i_op == aat_pkg::DP_APPEND) begin
            w_we = 1'b1;
        end else if (i_op == aat_pkg::DP_DEL_SHIFT && r_pend) begin
            // move the entry one slot down to close the gap
            w_we      = 1'b1;
            w_wr_addr = AW'(r_pend_addr - CW'(1));
            w_wr_data = r_rd_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
        if (w_rd_en) begin
            r_rd_data <= r_mem[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_op == aat_pkg::DP_CAPTURE) begin
            r_req <= i_req;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crit_lvl <= aat_pkg::CRITICAL_RESET;
            r_maj_lvl  <= aat_pkg::MAJOR_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                aat_pkg::CFG_CRITICAL: r_crit_lvl <= i_cfg_data;
                aat_pkg::CFG_MAJOR:    r_maj_lvl  <= i_cfg_data;
                default:               r_maj_lvl  <= r_maj_lvl;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_crit      <= '0;
            r_maj       <= '0;
            r_min       <= '0;
            r_beep      <= 1'b0;
            r_acc_crit  <= '0;
            r_acc_maj   <= '0;
            r_acc_min   <= '0;
            r_ptr       <= '0;
            r_pend      <= 1'b0;
            r_pend_addr <= '0;
            r_rem       <= '0;
        end else begin
            case (i_op)
                aat_pkg::DP_CAPTURE: begin
                    r_ptr  <= r_count;
                    r_pend <= 1'b0;
                end
                aat_pkg::DP_APPEND: begin
                    r_count <= r_count + CW'(1);
                end
                aat_pkg::DP_REC_INIT: begin
                    r_ptr      <= '0;
                    r_pend     <= 1'b0;
                    r_acc_crit <= '0;
                    r_acc_maj  <= '0;
                    r_acc_min  <= '0;
                end
                aat_pkg::DP_REC_STEP: begin
                    if (r_ptr != r_count) begin
                        r_ptr  <= r_ptr + CW'(1);
                        r_pend <= 1'b1;
                    end else begin
                        r_pend <= 1'b0;
                    end
                    if (r_pend) begin
                        // critical wins when both levels hold the same code
                        if (w_sev == r_crit_lvl) begin
                            r_acc_crit <= r_acc_crit + CW'(1);
                        end else if (w_sev == r_maj_lvl) begin
                            r_acc_maj <= r_acc_maj + CW'(1);
                        end else begin
                            r_acc_min <= r_acc_min + CW'(1);
                        end
                    end
                    if (w_rec_done) begin
                        r_crit <= r_acc_crit;
                        r_maj  <= r_acc_maj;
                        r_min  <= r_acc_min;
                        if (r_acc_crit == '0 && r_acc_maj == '0) begin
                            r_beep <= 1'b0;
                        end else if (r_acc_maj > r_maj || r_acc_crit > r_crit) begin
                            r_beep <= 1'b1;
                        end
                    end
                end
                aat_pkg::DP_DEL_SEARCH: begin
                    // walk from the newest slot down
                    if (w_hit) begin
                        r_ptr  <= r_pend_addr + CW'(1);
                        r_pend <= 1'b0;
                    end else if (r_ptr != '0) begin
                        r_ptr       <= r_ptr - CW'(1);
                        r_pend      <= 1'b1;
                        r_pend_addr <= r_ptr - CW'(1);
                    end else begin
                        r_pend <= 1'b0;
                    end
                end
                aat_pkg::DP_DEL_SHIFT: begin
                    if (r_ptr < r_count) begin
                        r_ptr       <= r_ptr + CW'(1);
                        r_pend      <= 1'b1;
                        r_pend_addr <= r_ptr;
                    end else begin
                        r_pend <= 1'b0;
                    end
                    if (w_shift_done) begin
                        r_count <= r_count - CW'(1);
                    end
                end
                aat_pkg::DP_RD_INIT: begin
                    r_ptr <= CW'(r_req.read_index);
                    r_rem <= 6'(w_n);
                end
                aat_pkg::DP_RD_EMIT: begin
                    r_ptr <= r_ptr + CW'(1);
                    r_rem <= r_rem - 6'd1;
                end
                default: r_rem <= r_rem;
            endcase
        end
    end

    assign w_load = (i_op == aat_pkg::DP_RD_EMIT) || (i_op == aat_pkg::DP_ACK)
                 || (i_op == aat_pkg::DP_NAK);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (i_rsp_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out.ok             <= (i_op != aat_pkg::DP_NAK);
            r_out.entry_id       <= (i_op == aat_pkg::DP_RD_EMIT) ? r_rd_data.id : 16'd0;
            r_out.entry_value    <= (i_op == aat_pkg::DP_RD_EMIT) ? r_rd_data.value : 16'd0;
            r_out.total_count    <= aat_pkg::CNT_OUT_W'(r_count);
            r_out.critical_count <= aat_pkg::CNT_OUT_W'(r_crit);
            r_out.major_count    <= aat_pkg::CNT_OUT_W'(r_maj);
            r_out.minor_count    <= aat_pkg::CNT_OUT_W'(r_min);
            r_out.alarm_active   <= (r_count != '0);
            r_out.beep           <= r_beep;
            r_out.last           <= (i_op != aat_pkg::DP_RD_EMIT) || (r_rem == 6'd1);
        end
    end

    assign o_rsp_valid = r_out_valid;
    assign o_rsp       = r_out;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_ALARMS))
        else $error("entry count beyond table depth");

    a_append_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_op == aat_pkg::DP_APPEND) |-> (r_count < CW'(MAX_ALARMS)))
        else $error("append into a full table");

    a_ack_sums: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_op == aat_pkg::DP_ACK) |->
            ((CW+2)'(r_crit) + (CW+2)'(r_maj) + (CW+2)'(r_min) == (CW+2)'(r_count)))
        else $error("severity counts do not add up to entry count");

    a_beep_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_beep |-> (r_crit != '0 || r_maj != '0))
        else $error("beep set with no critical or major alarm");

    a_emit_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |-> w_slot_free)
        else $error("output word overwritten before it was taken");
`endif

endmodule

[rtl/core/active_alarm_table.sv]
// ----------------------------------------------------------------------------
// Active alarm table
// Bounded newest-first alarm list with append, delete by id, severity
// recount, alarm/beep flags and ranged reads.
//
//   channel   dir   payload      words per request
//   i_req     in    t_req        one request word
//   o_rsp     out   t_rsp        one word; a read gives one per entry (<=32)
//   i_cfg_*   in    level write  -
//
// Append and a matched delete end in a severity recount; delete searches from
// the newest entry down to the first match, or to the oldest on no match: one
// entry per cycle for search, gap closing and the severity recount. A read
// fetches and then emits one entry at a time.
// Reset is synchronous; the table starts empty, no sweep.
// A stalled o_rsp holds the word and pauses the sequence; i_req is taken
// again once the last word of a request is in the output register.
// ----------------------------------------------------------------------------
module active_alarm_table #(
    parameter int unsigned MAX_ALARMS = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    aat_chan_if.sink   i_req,
    aat_chan_if.source o_rsp,
    input  logic       i_cfg_we,
    input  logic       i_cfg_idx,
    input  logic [1:0] i_cfg_data
);

    aat_pkg::t_dp_op  w_op;
    aat_pkg::t_status w_status;
    aat_pkg::t_req    w_req;
    aat_pkg::t_rsp    w_rsp;
    logic             w_ready;
    logic             w_rsp_valid;

    assign w_req         = i_req.payload;
    assign i_req.ready   = w_ready;
    assign o_rsp.valid   = w_rsp_valid;
    assign o_rsp.payload = w_rsp;

    aat_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_req.valid),
        .i_req_type (w_req.req_type),
        .o_ready    (w_ready),
        .o_op       (w_op),
        .i_status   (w_status)
    );

    aat_dp #(
        .MAX_ALARMS (MAX_ALARMS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_req       (w_req),
        .i_op        (w_op),
        .o_status    (w_status),
        .o_rsp_valid (w_rsp_valid),
        .i_rsp_ready (o_rsp.ready),
        .o_rsp       (w_rsp)
    );

endmodule

[test/active_alarm_table_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Active alarm table: regression bench
// Drives append, delete, read and unknown-code requests through the request
// channel under several severity level settings, predicts every response word
// from a model of the newest-first list, and compares each word field by field.
// ----------------------------------------------------------------------------
module active_alarm_table_tb;
    import aat_pkg::*;

    localparam int unsigned MAX_ALARMS     = 32;
    localparam int unsigned HOLD_CYCLES    = 300;
    localparam int unsigned SETTLE_CYCLES  = 150;
    localparam int unsigned WATCHDOG_LIMIT = 4000;

    // request code the block does not know
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    class alarm_table_scoreboard;
        logic [15:0] id_store [MAX_ALARMS];
        logic [15:0] value_store [MAX_ALARMS];
        int unsigned entry_total;
        int unsigned crit_total;
        int unsigned major_total;
        int unsigned minor_total;
        bit          beep_flag;
        logic [1:0]  critical_level;
        logic [1:0]  major_level;
        t_rsp        pending_words [$];
        int unsigned mismatches;
        int unsigned word_index;

        function new();
            entry_total    = 0;
            crit_total     = 0;
            major_total    = 0;
            minor_total    = 0;
            beep_flag      = 1'b0;
            critical_level = CRITICAL_RESET;
            major_level    = MAJOR_RESET;
            mismatches     = 0;
            word_index     = 0;
        endfunction

        task report(string msg);
            $display("mismatch at word %0d: %s", word_index, msg);
            mismatches++;
        endtask

        function void recount_severity();
            int unsigned crit;
            int unsigned maj;
            int unsigned minr;
            logic [1:0]  sev;
            crit = 0;
            maj  = 0;
            minr = 0;
            for (int unsigned i = 0; i < entry_total; i++) begin
                sev = id_store[i][SEV_LSB +: SEV_W];
                if (sev == critical_level) begin
                    crit++;
                end else if (sev == major_level) begin
                    maj++;
                end else begin
                    minr++;
                end
            end
            if (maj > major_total || crit > crit_total) begin
                beep_flag = 1'b1;
            end
            crit_total  = crit;
            major_total = maj;
            minor_total = minr;
            if (crit == 0 && maj == 0) begin
                beep_flag = 1'b0;
            end
        endfunction

        function void push_word(bit ok, logic [15:0] id, logic [15:0] value, bit last);
            t_rsp w;
            w.ok             = ok;
            w.entry_id       = id;
            w.entry_value    = value;
            w.total_count    = 6'(entry_total);
            w.critical_count = 6'(crit_total);
            w.major_count    = 6'(major_total);
            w.minor_count    = 6'(minor_total);
            w.alarm_active   = (entry_total > 0);
            w.beep           = beep_flag;
            w.last           = last;
            pending_words.push_back(w);
        endfunction

        function void note_request(t_req r);
            int unsigned pos;
            int unsigned n;
            case (r.req_type)
                REQ_APPEND: begin
                    if (entry_total >= MAX_ALARMS) begin
                        push_word(1'b0, '0, '0, 1'b1);
                    end else begin
                        for (int unsigned i = entry_total; i > 0; i--) begin
                            id_store[i]    = id_store[i-1];
                            value_store[i] = value_store[i-1];
                        end
                        id_store[0]    = r.alm_id;
                        value_store[0] = r.alm_value;
                        entry_total++;
                        recount_severity();
                        push_word(1'b1, '0, '0, 1'b1);
                    end
                end
                REQ_DELETE: begin
                    pos = 0;
                    while (pos < entry_total && id_store[pos] != r.alm_id) begin
                        pos++;
                    end
                    if (pos >= entry_total) begin
                        push_word(1'b0, '0, '0, 1'b1);
                    end else begin
                        // close the gap, keep the order of the rest
                        for (int unsigned i = pos; i + 1 < entry_total; i++) begin
                            id_store[i]    = id_store[i+1];
                            value_store[i] = value_store[i+1];
                        end
                        entry_total--;
                        recount_severity();
                        push_word(1'b1, '0, '0, 1'b1);
                    end
                end
                REQ_READ: begin
                    if (r.read_index >= entry_total) begin
                        push_word(1'b0, '0, '0, 1'b1);
                    end else begin
                        n = entry_total - r.read_index;
                        if (r.read_count < n) begin
                            n = r.read_count;
                        end
                        if (n > RESULT_LIMIT) begin
                            n = RESULT_LIMIT;
                        end
                        for (int unsigned i = 0; i < n; i++) begin
                            push_word(1'b1, id_store[r.read_index + i],
                                      value_store[r.read_index + i], (i + 1 == n));
                        end
                    end
                end
                default: begin
                    push_word(1'b0, '0, '0, 1'b1);
                end
            endcase
        endfunction

        task check_field(string name, logic [15:0] got, logic [15:0] want);
            if (got !== want) begin
                report($sformatf("%s got %0h want %0h", name, got, want));
            end
        endtask

        task check_word(t_rsp w);
            t_rsp want;
            if (pending_words.size() == 0) begin
                report("response word with nothing pending");
            end else begin
                want = pending_words.pop_front();
                check_field("ok", w.ok, want.ok);
                check_field("entry_id", w.entry_id, want.entry_id);
                check_field("entry_value", w.entry_value, want.entry_value);
                check_field("total_count", w.total_count, want.total_count);
                check_field("critical_count", w.critical_count, want.critical_count);
                check_field("major_count", w.major_count, want.major_count);
                check_field("minor_count", w.minor_count, want.minor_count);
                check_field("alarm_active", w.alarm_active, want.alarm_active);
                check_field("beep", w.beep, want.beep);
                check_field("last", w.last, want.last);
            end
            word_index++;
        endtask
    endclass

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic       i_cfg_idx;
    logic [1:0] i_cfg_data;

    aat_chan_if #(.t_payload(t_req)) req_ch ();
    aat_chan_if #(.t_payload(t_rsp)) rsp_ch ();

    active_alarm_table #(
        .MAX_ALARMS(MAX_ALARMS)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_ch),
        .o_rsp      (rsp_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    alarm_table_scoreboard sb = new();

    bit sink_stalls = 1'b0;
    bit source_gaps = 1'b0;
    bit hold_sink   = 1'b0;

    always #2 i_clk = ~i_clk;

    // response side: random ready bursts, plus one long hold on request
    initial begin : sink_driver
        rsp_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) begin
            @(posedge i_clk);
        end
        forever begin
            if (hold_sink) begin
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_sink = 1'b0;
            end else if (sink_stalls && $urandom_range(0, 3) == 0) begin
                rsp_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end else begin
                rsp_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            sb.check_word(rsp_ch.payload);
        end
    end

    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (req_ch.valid && req_ch.ready) ||
                (rsp_ch.valid && rsp_ch.ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("active_alarm_table regression: fail");
        $finish;
    end

    function automatic t_req make_req(logic [1:0] kind, logic [15:0] id,
                                      logic [15:0] value, logic [4:0] idx,
                                      logic [5:0] cnt);
        t_req r;
        r.req_type   = kind;
        r.alm_id     = id;
        r.alm_value  = value;
        r.read_index = idx;
        r.read_count = cnt;
        return r;
    endfunction

    // mostly well-formed: deletes aim at stored ids, reads at stored positions
    function automatic t_req random_request(int unsigned append_pct,
                                            int unsigned delete_pct);
        t_req        r;
        int unsigned roll;
        int unsigned n;
        n            = sb.entry_total;
        roll         = $urandom_range(0, 99);
        r.alm_id     = 16'($urandom);
        r.alm_value  = 16'($urandom);
        r.read_index = 5'($urandom);
        r.read_count = 6'($urandom_range(0, 32));
        if (roll < append_pct) begin
            r.req_type = REQ_APPEND;
            if (n > 0 && $urandom_range(0, 7) == 0) begin
                r.alm_id = sb.id_store[$urandom_range(0, n - 1)];
            end
        end else if (roll < append_pct + delete_pct) begin
            r.req_type = REQ_DELETE;
            if (n > 0 && $urandom_range(0, 3) != 0) begin
                r.alm_id = sb.id_store[$urandom_range(0, n - 1)];
            end
        end else if (roll < 97) begin
            r.req_type = REQ_READ;
            if (n > 0 && $urandom_range(0, 4) != 0) begin
                r.read_index = 5'($urandom_range(0, n - 1));
            end
            if ($urandom_range(0, 1) == 0) begin
                r.read_count = 6'($urandom_range(0, 4));
            end
        end else begin
            r.req_type = REQ_UNUSED;
        end
        return r;
    endfunction

    // entered just after a rising edge; returns once the word is taken and any random gap is over
    task issue_request(t_req r);
        req_ch.valid   <= 1'b1;
        req_ch.payload <= r;
        do begin
            @(posedge i_clk);
        end while (!req_ch.ready);
        sb.note_request(r);
        if (source_gaps && $urandom_range(0, 3) == 0) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    // drop valid, let every pending word drain and the block go idle
    task settle();
        req_ch.valid <= 1'b0;
        while (sb.pending_words.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task write_levels(logic [1:0] crit, logic [1:0] maj);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_CRITICAL;
        i_cfg_data <= crit;
        @(posedge i_clk);
        sb.critical_level = crit;
        i_cfg_idx  <= CFG_MAJOR;
        i_cfg_data <= maj;
        @(posedge i_clk);
        sb.major_level = maj;
        i_cfg_we <= 1'b0;
    endtask

    task run_directed();
        issue_request(make_req(REQ_READ, 16'h0000, 16'h0000, 5'd0, 6'd1));
        issue_request(make_req(REQ_DELETE, 16'h1234, 16'h0000, 5'd0, 6'd0));
        issue_request(make_req(REQ_UNUSED, 16'hFFFF, 16'hFFFF, 5'd31, 6'd32));
        issue_request(make_req(REQ_APPEND, 16'h0000, 16'h0000, 5'd0, 6'd0));
        issue_request(make_req(REQ_APPEND, 16'hFFFF, 16'hFFFF, 5'd31, 6'd32));
        issue_request(make_req(REQ_APPEND, 16'h0200, 16'h1111, 5'd0, 6'd0));
        issue_request(make_req(REQ_APPEND, 16'h0100, 16'hAAAA, 5'd0, 6'd0));
        issue_request(make_req(REQ_APPEND, 16'h0300, 16'h5555, 5'd0, 6'd0));
        // duplicate id: the delete below must take this newer one
        issue_request(make_req(REQ_APPEND, 16'h0200, 16'h2222, 5'd0, 6'd0));
        issue_request(make_req(REQ_READ, 16'h0000, 16'h0000, 5'd0, 6'd32));
        issue_request(make_req(REQ_READ, 16'h0000, 16'h0000, 5'd2, 6'd2));
        issue_request(make_req(REQ_READ, 16'h0000, 16'h0000, 5'd0, 6'd0));
        issue_request(make_req(REQ_READ, 16'h0000, 16'h0000, 5'd6, 6'd5));
        issue_request(make_req(REQ_READ, 16'h0000, 16'h0000, 5'd31, 6'd32));
        issue_request(make_req(REQ_DELETE, 16'h0200, 16'h0000, 5'd0, 6'd0));
        issue_request(make_req(REQ_DELETE, 16'hFFFF, 16'h0000, 5'd0, 6'd0));
        issue_request(make_req(REQ_DELETE, 16'hBEEF, 16'h0000, 5'd0, 6'd0));
        issue_request(make_req(REQ_READ, 16'h0000, 16'h0000, 5'd0, 6'd32));
        issue_request(make_req(REQ_READ, 16'h0000, 16'h0000, 5'd3, 6'd1));
        issue_request(make_req(REQ_DELETE, 16'h0300, 16'h0000, 5'd0, 6'd0));
        issue_request(make_req(REQ_DELETE, 16'h0200, 16'h0000, 5'd0, 6'd0));
        issue_request(make_req(REQ_DELETE, 16'h0100, 16'h0000, 5'd0, 6'd0));
        issue_request(make_req(REQ_DELETE, 16'h0000, 16'h0000, 5'd0, 6'd0));
        issue_request(make_req(REQ_READ, 16'h0000, 16'h0000, 5'd0, 6'd32));
    endtask

    task run_phase(logic [1:0] crit, logic [1:0] maj, int unsigned append_pct,
                   int unsigned delete_pct, int unsigned items, bit pressure);
        settle();
        write_levels(crit, maj);
        for (int unsigned k = 0; k < items; k++) begin
            if (pressure && k == items / 3) begin
                hold_sink = 1'b1;
            end
            issue_request(random_request(append_pct, delete_pct));
        end
    endtask

    initial begin : stimulus
        i_rst_n        <= 1'b0;
        i_cfg_we       <= 1'b0;
        i_cfg_idx      <= CFG_CRITICAL;
        i_cfg_data     <= 2'd0;
        req_ch.valid   <= 1'b0;
        req_ch.payload <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        write_levels(CRITICAL_RESET, MAJOR_RESET);
        sink_stalls = 1'b1;
        source_gaps = 1'b1;
        run_directed();

        // fill to full, then churn, then drain toward empty
        run_phase(2'd3, 2'd2, 60, 25, 110, 1'b0);
        run_phase(2'd0, 2'd1, 45, 40, 100, 1'b1);
        run_phase(2'd2, 2'd2, 40, 45, 100, 1'b0);
        run_phase(2'd1, 2'd0, 30, 55, 90, 1'b0);
        settle();
        sink_stalls = 1'b0;
        source_gaps = 1'b0;
        run_phase(2'd0, 2'd3, 50, 35, 80, 1'b0);
        settle();

        if (sb.mismatches == 0) begin
            $display("active_alarm_table regression: pass");
        end else begin
            $display("active_alarm_table regression: fail");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/core/aat_pkg.sv
rtl/core/aat_chan_if.sv
rtl/core/aat_ctrl.sv
rtl/core/aat_dp.sv
rtl/core/active_alarm_table.sv
test/active_alarm_table_tb.sv
